// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_PATTERN_LENGTH      = 3'd0;
   localparam logic [2:0] REG_PATTERN_BYTES_LOW   = 3'd1;
   localparam logic [2:0] REG_PATTERN_BYTES_HIGH  = 3'd2;
   localparam logic [2:0] REG_REPLACE_LENGTH      = 3'd3;
   localparam logic [2:0] REG_REPLACE_BYTES_LOW   = 3'd4;
   localparam logic [2:0] REG_REPLACE_BYTES_HIGH  = 3'd5;

   // Byte capacity of the 128-bit pattern and replacement registers
   localparam int          RegBytes  = 16;
   localparam logic [4:0]  RepMax    = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_EMIT_OLD,
      ST_EMIT_REPL,
      ST_FLUSH,
      ST_MARK
   } sfr_state_type;

   // Pick byte idx out of a 16-byte register pair, byte 0 in the low bits
   function automatic logic [7:0] byte_sel(input logic [127:0] bytes,
                                           input logic [3:0]   idx);
      byte_sel = bytes[{idx, 3'b000} +: 8];
   endfunction

endpackage

// ===== hdl/stream_find_replace.sv =====
// Streaming find-and-replace on a byte stream.
// Input channel (req_): one text byte per transfer, req_in_last on the final
// byte of a stream. Result channel (rsp_): one byte per transfer; rsp_out_valid
// is low only on a bare end marker, rsp_out_last flags the final result.
// Configuration (csr_): index and 64-bit data, always ready; write only while
// the block is idle. A pattern_length write drops the pending bytes.
// Each byte is written into a pending window. Once the window holds
// pattern_length bytes, one shared byte comparator walks it against the
// pattern, one byte per cycle, stopping at the first mismatch. While the
// result slot is free the sequencer then sends results one per cycle: the
// replacement text on a match, else the oldest byte, plus the whole window
// on the final byte. req_stall is high while the sequencer is out of idle,
// through the compare and every result.
// A result waits in the output register while rsp_stall is high and the
// sequencer holds until it is taken; the next byte is accepted meanwhile
// once the sequencer is back in idle.
// Reset (synchronous): registers return to their reset values, the window
// is empty and no result is pending.
module stream_find_replace #(
   parameter int PATTERN_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import sfr_pkg::*;

   localparam int PAT_LIM = (PATTERN_MAX < RegBytes) ? PATTERN_MAX : RegBytes;
   localparam int IDX_W   = (PAT_LIM > 1) ? $clog2(PAT_LIM) : 1;
   localparam int CNT_W   = $clog2(PAT_LIM + 1);

   sfr_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, wr_pos, cnt_inc;
   logic [3:0]        idx_ff, idx_in;
   logic              last_ff, last_in;
   logic [7:0]        win_ff [PAT_LIM];
   logic [IDX_W-1:0]  rd_idx;
   logic [7:0]        win_rd;
   logic              win_wr, win_shift;

   logic [4:0]        plen_raw_ff, rlen_raw_ff;
   logic [63:0]       pat_lo_ff, pat_hi_ff, rep_lo_ff, rep_hi_ff;
   logic [4:0]        plen_eff, rlen_eff, idx5, cnt5;
   logic [7:0]        pat_byte, rep_byte;

   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_last_ff, out_last_in;
   logic              out_load, slot_free, csr_wr, plen_wr;

   // Effective lengths: empty pattern counts as one byte, both saturate
   always_comb begin
      plen_eff = plen_raw_ff;
      if (plen_raw_ff == 5'd0) begin
         plen_eff = 5'd1;
      end else if (plen_raw_ff > 5'(PAT_LIM)) begin
         plen_eff = 5'(PAT_LIM);
      end
      rlen_eff = (rlen_raw_ff > RepMax) ? RepMax : rlen_raw_ff;
   end

   assign idx5     = {1'b0, idx_ff};
   assign cnt5     = 5'(cnt_ff);
   assign pat_byte = byte_sel({pat_hi_ff, pat_lo_ff}, idx_ff);
   assign rep_byte = byte_sel({rep_hi_ff, rep_lo_ff}, idx_ff);
   assign win_rd   = win_ff[rd_idx];
   assign wr_pos   = (cnt5 >= plen_eff) ? '0 : cnt_ff;
   assign cnt_inc  = wr_pos + CNT_W'(1);

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign plen_wr   = csr_wr && (csr_index == REG_PATTERN_LENGTH);
   assign req_stall = (state_ff != ST_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_raw_ff <= 5'd1;
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         rlen_raw_ff <= '0;
         rep_lo_ff   <= '0;
         rep_hi_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            REG_PATTERN_LENGTH:     plen_raw_ff <= csr_wdata[4:0];
            REG_PATTERN_BYTES_LOW:  pat_lo_ff   <= csr_wdata;
            REG_PATTERN_BYTES_HIGH: pat_hi_ff   <= csr_wdata;
            REG_REPLACE_LENGTH:     rlen_raw_ff <= csr_wdata[4:0];
            REG_REPLACE_BYTES_LOW:  rep_lo_ff   <= csr_wdata;
            REG_REPLACE_BYTES_HIGH: rep_hi_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
      end
   end

   // Next state, window strobes and result load
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rd_idx       = idx_ff[IDX_W-1:0];
      win_wr       = 1'b0;
      win_shift    = 1'b0;
      out_load     = 1'b0;
      out_byte_in  = 8'h00;
      out_valid_in = 1'b0;
      out_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               win_wr  = 1'b1;
               last_in = req_in_last;
               cnt_in  = cnt_inc;
               idx_in  = '0;
               if (5'(cnt_inc) == plen_eff) begin
                  state_in = ST_COMPARE;
               end else if (req_in_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_COMPARE: begin
            if (win_rd != pat_byte) begin
               state_in = ST_EMIT_OLD;
            end else if (idx5 == plen_eff - 5'd1) begin
               cnt_in = '0;
               idx_in = '0;
               if (rlen_eff != 5'd0) begin
                  state_in = ST_EMIT_REPL;
               end else if (last_ff) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ST_EMIT_OLD: begin
            rd_idx = '0;
            if (slot_free) begin
               out_load     = 1'b1;
               out_byte_in  = win_rd;
               out_valid_in = 1'b1;
               out_last_in  = last_ff && (cnt5 == 5'd1);
               win_shift    = 1'b1;
               cnt_in       = cnt_ff - CNT_W'(1);
               idx_in       = '0;
               state_in     = (last_ff && (cnt5 != 5'd1)) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_EMIT_REPL: begin
            if (slot_free) begin
               out_load     = 1'b1;
               out_byte_in  = rep_byte;
               out_valid_in = 1'b1;
               out_last_in  = last_ff && (idx5 == rlen_eff - 5'd1);
               if (idx5 == rlen_eff - 5'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               out_load     = 1'b1;
               out_byte_in  = win_rd;
               out_valid_in = 1'b1;
               out_last_in  = (idx5 == cnt5 - 5'd1);
               if (idx5 == cnt5 - 5'd1) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_MARK: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Drop the pending bytes on a new pattern length
      if (plen_wr) begin
         cnt_in = '0;
      end
   end

   // Pending window: write at the fill position, shift down after the oldest leaves
   always_ff @(posedge clock) begin
      if (win_wr) begin
         win_ff[wr_pos[IDX_W-1:0]] <= req_in_byte;
      end else if (win_shift) begin
         for (int k = 0; k < PAT_LIM - 1; k++) begin
            win_ff[k] <= win_ff[k + 1];
         end
      end
   end

   // Output register: load when free, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff  <= out_byte_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_out_last  = out_last_ff;

`ifndef ASSERT_OFF
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a stalled result");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt5 <= 5'(PAT_LIM))
      else $error("pending count beyond window depth");

   a_compare_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> (idx5 < plen_eff))
      else $error("compare index beyond pattern length");

   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last_in) |=> (cnt_ff == '0 && state_ff == ST_IDLE))
      else $error("window not empty after end of stream");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (rsp_out_last && rsp_out_byte == 8'h00))
      else $error("malformed end marker");
`endif

endmodule

// ===== test/stream_find_replace_check.sv =====
`timescale 1ns / 1ps

module stream_find_replace_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_out_valid,
   input  logic        rsp_out_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          results_due,
   output int          fail_count
);
   import sfr_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } text_beat_type;

   // Shadow copy of the configuration
   logic [4:0]   find_len;
   logic [127:0] find_text;
   logic [4:0]   swap_len;
   logic [127:0] swap_text;

   // Shadow copy of the pending window
   logic [7:0]   held_text [RegBytes];
   int unsigned  held_count;

   text_beat_type text_due [$];

   // Queue one beat, never more than a window's worth per byte
   task automatic push_beat(input logic [7:0] b, input logic v, inout int unsigned n);
      if (n < RegBytes) begin
         text_due.push_back({b, v, 1'b0});
         n++;
      end
   endtask

   // Work out the beats that one accepted text byte produces
   task automatic replace_step(input logic [7:0] b, input logic last);
      int unsigned   plen;
      int unsigned   rlen;
      int unsigned   n;
      int unsigned   i;
      bit            hit;
      text_beat_type tail;
      plen = (find_len == 5'd0) ? 1 : ((find_len > RegBytes) ? RegBytes : find_len);
      rlen = (swap_len > RepMax) ? RepMax : swap_len;
      n = 0;
      if (held_count >= plen)
         held_count = 0;
      held_text[held_count] = b;
      held_count++;

      // Full window: replace on a hit, else release the oldest byte
      if (held_count == plen) begin
         hit = 1'b1;
         for (i = 0; i < plen; i++)
            if (held_text[i] != find_text[8*i +: 8])
               hit = 1'b0;
         if (hit) begin
            for (i = 0; i < rlen; i++)
               push_beat(swap_text[8*i +: 8], 1'b1, n);
            held_count = 0;
         end else begin
            push_beat(held_text[0], 1'b1, n);
            for (i = 1; i < held_count; i++)
               held_text[i-1] = held_text[i];
            held_count--;
         end
      end

      // Final byte: flush the window and flag the closing beat
      if (last) begin
         for (i = 0; i < held_count; i++)
            push_beat(held_text[i], 1'b1, n);
         held_count = 0;
         if (n == 0)
            push_beat(8'h00, 1'b0, n);
         tail = text_due.pop_back();
         tail.out_last = 1'b1;
         text_due.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      text_beat_type want;
      if (reset) begin
         find_len   = 5'd1;
         find_text  = '0;
         swap_len   = 5'd0;
         swap_text  = '0;
         held_count = 0;
         fail_count = 0;
         text_due.delete();
      end else begin
         // Compare each result transfer with the oldest expected beat
         if (rsp_valid && !rsp_stall) begin
            if (text_due.size() == 0) begin
               $display("%0t: unexpected result byte %02h valid %0b last %0b",
                        $time, rsp_out_byte, rsp_out_valid, rsp_out_last);
               fail_count++;
            end else begin
               want = text_due.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_valid !== want.out_valid) begin
                  $display("%0t: out_valid expected %0b actual %0b",
                           $time, want.out_valid, rsp_out_valid);
                  fail_count++;
               end
               if (rsp_out_last !== want.out_last) begin
                  $display("%0t: out_last expected %0b actual %0b",
                           $time, want.out_last, rsp_out_last);
                  fail_count++;
               end
            end
         end

         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PATTERN_LENGTH: begin
                  find_len   = csr_wdata[4:0];
                  held_count = 0;
               end
               REG_PATTERN_BYTES_LOW:  find_text[63:0]   = csr_wdata;
               REG_PATTERN_BYTES_HIGH: find_text[127:64] = csr_wdata;
               REG_REPLACE_LENGTH:     swap_len          = csr_wdata[4:0];
               REG_REPLACE_BYTES_LOW:  swap_text[63:0]   = csr_wdata;
               REG_REPLACE_BYTES_HIGH: swap_text[127:64] = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && !req_stall)
            replace_step(req_in_byte, req_in_last);
      end
      results_due <= text_due.size();
   end

endmodule

// ===== test/stream_find_replace_test.sv =====
`timescale 1ns / 1ps

module stream_find_replace_test;
   import sfr_pkg::*;

   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 40;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 130;
   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = '0;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_out_last;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index   = '0;
   logic [63:0] csr_wdata   = '0;

   int           results_due;
   int           fail_count;
   int unsigned  items_sent = 0;
   bit           hold_rsp   = 1'b0;
   int unsigned  gen_plen   = 1;
   logic [127:0] gen_pattern = '0;
   logic [7:0]   stream_q [$];

   stream_find_replace dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   stream_find_replace_check scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .results_due   (results_due),
      .fail_count    (fail_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one text byte and hold it until the transfer
   task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Send the bytes in stream_q, optionally closing the stream
   task automatic send_stream(input bit burst, input bit close);
      int unsigned i;
      int unsigned gap;
      for (i = 0; i < stream_q.size(); i++) begin
         gap = burst ? 0 : pick_gap();
         if (i == stream_q.size() - 1)
            gap = gap + 1;
         send_byte(stream_q[i], close && (i == stream_q.size() - 1), gap);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for every expected beat, then let the compare logic go quiet
   task automatic drain();
      do @(posedge clock); while (results_due != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write all six registers; junk above the length fields
   task automatic configure(input logic [4:0] plen, input logic [127:0] pat,
                            input logic [4:0] rlen, input logic [127:0] rep);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      write_reg(REG_PATTERN_LENGTH, {junk[63:5], plen});
      write_reg(REG_PATTERN_BYTES_LOW, pat[63:0]);
      write_reg(REG_PATTERN_BYTES_HIGH, pat[127:64]);
      junk = {$urandom(), $urandom()};
      write_reg(REG_REPLACE_LENGTH, {junk[63:5], rlen});
      write_reg(REG_REPLACE_BYTES_LOW, rep[63:0]);
      write_reg(REG_REPLACE_BYTES_HIGH, rep[127:64]);
      gen_plen    = (plen == 5'd0) ? 1 : ((plen > RegBytes) ? RegBytes : plen);
      gen_pattern = pat;
   endtask

   // Result side: random stall stretches, or one long hold on request
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned free_left;
      bit          hold_seen;
      stall_left = 0;
      free_left  = 0;
      hold_seen  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_seen) begin
            hold_seen  = 1'b1;
            stall_left = LONG_HOLD;
            free_left  = 0;
         end
         if (stall_left == 0 && free_left == 0) begin
            stall_left = pick_gap();
            free_left  = $urandom_range(1, 40);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            free_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   // Give up when no transfer of any kind happens for too long
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("stream_find_replace_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned  base;
      int unsigned  phase;
      int unsigned  roll;
      int unsigned  plen_w;
      int unsigned  rlen_w;
      int unsigned  want;
      int unsigned  cut;
      int unsigned  k;
      int unsigned  s;
      int unsigned  streams;
      bit           burst;
      bit           close;
      logic [127:0] pat;
      logic [127:0] rep;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a single zero byte is deleted, so the final zero ends in a marker
      stream_q = '{8'h00, 8'hFF, 8'h00};
      send_stream(1'b0, 1'b1);

      // Match on the final byte with an empty replacement
      drain();
      configure(5'd3, 128'h636261, 5'd0, '0);
      stream_q = '{8'h61, 8'h62, 8'h63};
      send_stream(1'b0, 1'b1);

      // Oversized replacement length saturates to the full sixteen bytes
      drain();
      configure(5'd2, 128'h7978, 5'd31,
                {$urandom(), $urandom(), $urandom(), $urandom()});
      stream_q = '{8'h78, 8'h79, 8'h7A};
      send_stream(1'b1, 1'b1);

      // Oversized pattern length saturates; a short stream only flushes
      drain();
      configure(5'd31, {$urandom(), $urandom(), $urandom(), $urandom()}, 5'd5,
                {$urandom(), $urandom(), $urandom(), $urandom()});
      stream_q = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01};
      send_stream(1'b0, 1'b1);

      // Zero pattern length acts as one byte
      drain();
      configure(5'd0, 128'hFF, 5'd2, 128'h8001);
      stream_q = '{8'hFF, 8'h7F};
      send_stream(1'b0, 1'b1);

      // Rewrite the pattern length mid-stream: pending bytes are dropped
      drain();
      configure(5'd4, 128'h04030201, 5'd16, ~128'h0);
      stream_q = '{8'h01, 8'h02};
      send_stream(1'b0, 1'b0);
      drain();
      write_reg(REG_PATTERN_LENGTH, {$urandom(), 27'h0, 5'd4});
      stream_q = '{8'h03};
      send_stream(1'b0, 1'b1);

      // Unused register indexes change nothing; then a full match
      drain();
      write_reg(REG_SPARE_A, {$urandom(), $urandom()});
      write_reg(REG_SPARE_B, {$urandom(), $urandom()});
      stream_q = '{8'hA5};
      send_stream(1'b0, 1'b1);
      stream_q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'hFF};
      send_stream(1'b0, 1'b1);

      // Random phases: new settings, then mostly well-formed text
      base  = items_sent;
      phase = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         drain();
         roll = $urandom_range(0, 99);
         if (roll < 60)
            plen_w = $urandom_range(1, 4);
         else if (roll < 80)
            plen_w = $urandom_range(5, 15);
         else if (roll < 90)
            plen_w = 16;
         else if (roll < 95)
            plen_w = 0;
         else
            plen_w = $urandom_range(17, 31);
         roll = $urandom_range(0, 99);
         if (roll < 15)
            rlen_w = 0;
         else if (roll < 70)
            rlen_w = $urandom_range(1, 4);
         else if (roll < 85)
            rlen_w = $urandom_range(5, 15);
         else if (roll < 93)
            rlen_w = 16;
         else
            rlen_w = $urandom_range(17, 31);
         pat = {$urandom(), $urandom(), $urandom(), $urandom()};
         // Narrow alphabet half the time so near-matches overlap
         if ($urandom_range(0, 1) == 1)
            for (k = 0; k < RegBytes; k++)
               pat[8*k +: 8] = 8'h61 + pat[8*k];
         rep = {$urandom(), $urandom(), $urandom(), $urandom()};
         configure(plen_w[4:0], pat, rlen_w[4:0], rep);

         // Long result hold once, with the sender still pushing
         if (phase == 1)
            hold_rsp = 1'b1;

         streams = $urandom_range(1, 3);
         for (s = 0; s < streams; s++) begin
            want = $urandom_range(1, 2 * gen_plen + 4);
            if (phase == 1 && s == 0)
               want = want + 24;
            stream_q.delete();
            while (stream_q.size() < want) begin
               roll = $urandom_range(0, 99);
               if (roll < 45) begin
                  for (k = 0; k < gen_plen; k++)
                     stream_q.push_back(gen_pattern[8*k +: 8]);
               end else if (roll < 65) begin
                  cut = $urandom_range(0, gen_plen - 1);
                  for (k = 0; k < cut; k++)
                     stream_q.push_back(gen_pattern[8*k +: 8]);
                  stream_q.push_back(8'($urandom_range(0, 255)));
               end else if (roll < 85) begin
                  k = $urandom_range(0, gen_plen - 1);
                  stream_q.push_back(gen_pattern[8*k +: 8]);
               end else begin
                  stream_q.push_back(8'($urandom_range(0, 255)));
               end
            end
            // Leave the final stream of a phase open now and then
            close = (s + 1 < streams) || ($urandom_range(0, 99) < 80);
            burst = ($urandom_range(0, 3) == 0);
            send_stream(burst, close);
         end
         phase++;
      end

      drain();
      if (fail_count == 0)
         $display("stream_find_replace_test: PASS");
      else
         $display("stream_find_replace_test: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sfr_pkg.sv
hdl/stream_find_replace.sv
test/stream_find_replace_check.sv
test/stream_find_replace_test.sv
